>>> rtl/core/rpbd_pkg.sv
// Shared types, constants and codes for the record page buffer directory.
// Used by the shared divider and by the top level; depends on nothing.
package rpbd_pkg;

  // Buffer geometry.
  localparam int WAYS   = 3;
  localparam int SLOT_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  // Field widths of the streams and registers.
  localparam int CMD_W   = 3;
  localparam int RID_W   = 16;
  localparam int KIND_W  = 2;
  localparam int PAGE_W  = 16;
  localparam int POS_W   = 2;
  localparam int OFF_W   = 7;
  localparam int RSZ_W   = 7;
  localparam int CNT_W   = 17;
  localparam int CFG_W   = 17;
  localparam int CIDX_W  = 2;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 32;

  // Divider geometry: record id over records per page.
  localparam int DIV_STEPS = RID_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_OPEN   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_COMMIT = 3'd5;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_WRITEBACK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FETCH     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE      = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REJECT    = 2'd3;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_RECORD_SIZE  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_RECS_PER_PG  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_START_RECS   = 2'd2;
  localparam logic [CIDX_W-1:0] REG_START_PAGES  = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [RSZ_W-1:0] RSIZE_RST = 7'd80;
  localparam logic [RSZ_W-1:0] RPP_RST   = 7'd1;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [RID_W-1:0] dividend;
    logic [RSZ_W-1:0] divisor;
  } div_req_t;

  // Answer of the shared divider.
  typedef struct packed {
    logic              done;
    logic [RID_W-1:0]  quotient;
    logic [RSZ_W-1:0]  remainder;
  } div_rsp_t;

  // Pack one result word, first field in the lowest bits.
  function automatic logic [OUT_W-1:0] pack_result(
    input logic [KIND_W-1:0] kind,
    input logic [PAGE_W-1:0] page,
    input logic [POS_W-1:0]  pos,
    input logic [OFF_W-1:0]  off,
    input logic              res
  );
    logic [OUT_W-1:0] w;
    w = '0;
    w[KIND_W-1:0] = kind;
    w[KIND_W +: PAGE_W] = page;
    w[KIND_W+PAGE_W +: POS_W] = pos;
    w[KIND_W+PAGE_W+POS_W +: OFF_W] = off;
    w[KIND_W+PAGE_W+POS_W+OFF_W] = res;
    return w;
  endfunction

endpackage

>>> rtl/core/rpbd_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on rpbd_pkg for widths and the request and answer structs.
module rpbd_divider
  import rpbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [RID_W-1:0]  quo_r;
  logic [RSZ_W-1:0]  rem_r;
  logic [RSZ_W-1:0]  dvsr_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              done_r;
  logic [RSZ_W:0]    shifted;
  logic              ge;
  logic [RSZ_W:0]    diff;

  // One trial subtraction of the partial remainder.
  always_comb begin
    shifted = {rem_r, quo_r[RID_W-1]};
    ge      = (shifted >= {1'b0, dvsr_r});
    diff    = shifted - {1'b0, dvsr_r};
  end

  // Step counter and the shifting quotient and remainder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvsr_r <= req.divisor;
        cnt_r  <= DCNT_W'(DIV_STEPS);
      end else if (cnt_r != '0) begin
        quo_r <= {quo_r[RID_W-2:0], ge};
        rem_r <= ge ? diff[RSZ_W-1:0] : shifted[RSZ_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

>>> rtl/core/record_page_buffer_directory.sv
// Directory of a small FIFO page buffer for fixed-size records.
// Depends on rpbd_pkg and instantiates the shared divider rpbd_divider.
//
// Usage: the input stream carries one command word per transfer (open, insert,
// read, delete, update, commit with a record id). The output stream returns
// one to four result words per command: write-backs, fetches, then a done or
// a rejection word, the final one flagged by out_tlast. The user must write the
// registers on the cfg port (record size, records per page, start counts) only
// while idle; the block itself does not enforce this.
//
// Timing: in_tready is high only while no command is in progress. Read, delete,
// update and insert run the record id through a shared one-bit-per-cycle
// divider; an access then passes quotient pickup and lookup, an eviction and a
// fetch where needed, and the done word.
//
// Reset clears the slots, the counts and the output word and loads the
// register defaults (record size 80, one record per page). A stalled output
// holds its word; the sequencer waits before each further word, so nothing
// is lost, and the next command may be taken while the last word waits.
module record_page_buffer_directory
  import rpbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Input words: cmd, record_id.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,
  // Result words: kind, page_id, position, byte_offset, resident.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,
  output logic              out_tlast,
  // Configuration writes.
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_LOOK, S_EVICT, S_FETCH, S_DONE, S_SCAN, S_END
  } state_t;

  state_t             state_r;
  logic [RSZ_W-1:0]   rsize_r;
  logic [RSZ_W-1:0]   rpp_r;
  logic [CNT_W-1:0]   start_rec_r;
  logic [CNT_W-1:0]   start_pg_r;
  logic [PAGE_W-1:0]  slot_page_r [WAYS];
  logic [WAYS-1:0]    slot_valid_r;
  logic [CNT_W-1:0]   rec_cnt_r;
  logic [CNT_W-1:0]   pg_cnt_r;
  logic [PAGE_W-1:0]  page_r;
  logic [RSZ_W-1:0]   rem_r;
  logic [OFF_W-1:0]   off_r;
  logic               is_ins_r;
  logic               fetch_r;
  logic [SLOT_W-1:0]  place_r;
  logic [SLOT_W-1:0]  idx_r;
  logic [KIND_W-1:0]  scan_kind_r;
  logic [KIND_W-1:0]  end_kind_r;
  logic               out_tvalid_r;
  logic [OUT_W-1:0]   out_tdata_r;
  logic               out_tlast_r;

  logic [CMD_W-1:0]   in_cmd;
  logic [RID_W-1:0]   in_rid;
  logic               accept;
  logic               can_emit;
  logic               emit_en;
  logic [OUT_W-1:0]   emit_word;
  logic               emit_last;
  logic               hit;
  logic [SLOT_W-1:0]  hit_idx;
  logic               free;
  logic [SLOT_W-1:0]  free_idx;
  logic [2*RSZ_W-1:0] off_prod;
  logic               rd_cmd;
  logic               rd_bad;
  logic               ins_ok;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign in_cmd    = in_tdata[CMD_W-1:0];
  assign in_rid    = in_tdata[CMD_W +: RID_W];
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign can_emit  = !out_tvalid_r || out_tready;

  // Command classes seen at acceptance.
  assign rd_cmd = (in_cmd == CMD_READ) || (in_cmd == CMD_DELETE) || (in_cmd == CMD_UPDATE);
  assign rd_bad = ({1'b0, in_rid} >= rec_cnt_r);
  assign ins_ok = !rec_cnt_r[CNT_W-1];

  // Start the divider on an access that passes its range check.
  always_comb begin
    div_req.start    = accept && ((rd_cmd && !rd_bad) || (in_cmd == CMD_INSERT && ins_ok));
    div_req.dividend = (in_cmd == CMD_INSERT) ? rec_cnt_r[RID_W-1:0] : in_rid;
    div_req.divisor  = (rpp_r == '0) ? RSZ_W'(1) : rpp_r;
  end

  rpbd_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Highest slot holding the page, and highest free slot.
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free     = 1'b0;
    free_idx = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (slot_valid_r[i] && slot_page_r[i] == page_r) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!slot_valid_r[i]) begin
        free     = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  // Record offset inside the page, low bits only.
  assign off_prod = rem_r * rsize_r;

  // Result word offered by the current state.
  always_comb begin
    emit_en   = 1'b0;
    emit_word = '0;
    emit_last = 1'b0;
    unique case (state_r)
      S_EVICT: begin
        emit_en   = 1'b1;
        emit_word = pack_result(KIND_WRITEBACK, slot_page_r[0], '0, '0, 1'b0);
      end
      S_FETCH: begin
        emit_en   = 1'b1;
        emit_word = pack_result(KIND_FETCH, page_r, POS_W'(place_r), '0, 1'b1);
      end
      S_DONE: begin
        emit_en   = 1'b1;
        emit_last = 1'b1;
        emit_word = hit ? pack_result(KIND_DONE, page_r, POS_W'(hit_idx), off_r, 1'b1)
                        : pack_result(KIND_DONE, page_r, '0, off_r, 1'b0);
      end
      S_SCAN: begin
        emit_en   = slot_valid_r[idx_r];
        emit_word = pack_result(scan_kind_r, slot_page_r[idx_r], POS_W'(idx_r), '0, 1'b1);
      end
      S_END: begin
        emit_en   = 1'b1;
        emit_last = 1'b1;
        emit_word = pack_result(end_kind_r, '0, '0, '0, 1'b0);
      end
      default: begin
        emit_en = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsize_r     <= RSIZE_RST;
      rpp_r       <= RPP_RST;
      start_rec_r <= '0;
      start_pg_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RECORD_SIZE: rsize_r     <= cfg_data[RSZ_W-1:0];
        REG_RECS_PER_PG: rpp_r       <= cfg_data[RSZ_W-1:0];
        REG_START_RECS:  start_rec_r <= cfg_data[CNT_W-1:0];
        REG_START_PAGES: start_pg_r  <= cfg_data[CNT_W-1:0];
      endcase
    end
  end

  // Sequencer, directory state and the output word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_valid_r <= '0;
      rec_cnt_r    <= '0;
      pg_cnt_r     <= '0;
      out_tvalid_r <= 1'b0;
      out_tdata_r  <= '0;
      out_tlast_r  <= 1'b0;
      idx_r        <= '0;
      for (int i = 0; i < WAYS; i++) begin
        slot_page_r[i] <= '0;
      end
    end else begin
      // Output register: load a new word or drain the taken one.
      if (emit_en && can_emit) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= emit_word;
        out_tlast_r  <= emit_last;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            idx_r <= '0;
            priority if (in_cmd == CMD_OPEN) begin
              rec_cnt_r <= start_rec_r;
              pg_cnt_r  <= start_pg_r;
              for (int i = 0; i < WAYS; i++) begin
                slot_valid_r[i] <= (start_pg_r > CNT_W'(i));
                slot_page_r[i]  <= (start_pg_r > CNT_W'(i)) ? PAGE_W'(i) : '0;
              end
              scan_kind_r <= KIND_FETCH;
              end_kind_r  <= KIND_DONE;
              state_r     <= S_SCAN;
            end else if (in_cmd == CMD_COMMIT) begin
              scan_kind_r <= KIND_WRITEBACK;
              end_kind_r  <= KIND_DONE;
              state_r     <= S_SCAN;
            end else if (in_cmd == CMD_INSERT && ins_ok) begin
              rec_cnt_r <= rec_cnt_r + 1'b1;
              is_ins_r  <= 1'b1;
              state_r   <= S_DIV;
            end else if (rd_cmd && !rd_bad) begin
              is_ins_r <= 1'b0;
              state_r  <= S_DIV;
            end else begin
              end_kind_r <= KIND_REJECT;
              state_r    <= S_END;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            page_r  <= div_rsp.quotient;
            rem_r   <= div_rsp.remainder;
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          off_r <= off_prod[OFF_W-1:0];
          priority if (is_ins_r && ({1'b0, page_r} >= pg_cnt_r)) begin
            // A new page: placed without a fetch.
            fetch_r <= 1'b0;
            if (pg_cnt_r != {CNT_W{1'b1}}) begin
              pg_cnt_r <= pg_cnt_r + 1'b1;
            end
            if (free) begin
              slot_page_r[free_idx]  <= page_r;
              slot_valid_r[free_idx] <= 1'b1;
              state_r                <= S_DONE;
            end else begin
              state_r <= S_EVICT;
            end
          end else if (!hit && ({1'b0, page_r} < pg_cnt_r)) begin
            fetch_r <= 1'b1;
            if (free) begin
              slot_page_r[free_idx]  <= page_r;
              slot_valid_r[free_idx] <= 1'b1;
              place_r                <= free_idx;
              state_r                <= S_FETCH;
            end else begin
              state_r <= S_EVICT;
            end
          end else begin
            state_r <= S_DONE;
          end
        end
        S_EVICT: begin
          // The page in slot 0 leaves, the rest move down, the new page goes on top.
          if (can_emit) begin
            for (int i = 0; i < WAYS - 1; i++) begin
              slot_page_r[i]  <= slot_page_r[i+1];
              slot_valid_r[i] <= slot_valid_r[i+1];
            end
            slot_page_r[WAYS-1]  <= page_r;
            slot_valid_r[WAYS-1] <= 1'b1;
            place_r              <= SLOT_W'(WAYS - 1);
            state_r              <= fetch_r ? S_FETCH : S_DONE;
          end
        end
        S_FETCH: begin
          if (can_emit) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (can_emit) begin
            state_r <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (can_emit || !slot_valid_r[idx_r]) begin
            if (idx_r == SLOT_W'(WAYS - 1)) begin
              state_r <= S_END;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        S_END: begin
          if (can_emit) begin
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for record_page_buffer_directory: directed rows, then random phases.
// A behavioral copy of the directory predicts every result word. Depends on rpbd_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rpbd_pkg::*;

  // Command codes that the block must reject.
  localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;
  localparam int MAX_RECS     = 65536;
  localparam int COUNT_TOP    = 'h1FFFF;
  localparam int TAIL_CYCLES  = 40;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 25;

  // One result word, unpacked into its fields.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PAGE_W-1:0] page;
    logic [POS_W-1:0]  pos;
    logic [OFF_W-1:0]  off;
    logic              res;
    logic              last;
  } result_word_t;

  // One row of the directed plan: a command, a command with a known answer, or a register write.
  typedef enum logic [1:0] {ROW_CMD, ROW_CHECKED, ROW_REG} row_kind_t;
  typedef struct packed {
    row_kind_t         row;
    logic [CMD_W-1:0]  cmd;
    logic [CIDX_W-1:0] idx;
    logic [CFG_W-1:0]  arg;
    logic [KIND_W-1:0] want;
  } plan_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  // Fields from bit 0 up: cmd, record_id, zero fill.
  logic [IN_W-1:0]   in_tdata;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // Fields from bit 0 up: kind, page_id, position, byte_offset, resident, zero fill.
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tlast;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]  cfg_data;

  // Behavioral copy of the directory state and its registers.
  logic [PAGE_W-1:0] dir_page [WAYS];
  bit                dir_valid [WAYS];
  logic [CNT_W-1:0]  dir_records;
  logic [CNT_W-1:0]  dir_pages;
  logic [RSZ_W-1:0]  reg_rsize;
  logic [RSZ_W-1:0]  reg_per_page;
  logic [CNT_W-1:0]  reg_start_recs;
  logic [CNT_W-1:0]  reg_start_pages;

  result_word_t expected_words[$];
  result_word_t step_words[$];
  result_word_t oldest;
  plan_row_t    plan[$];
  int           mismatches;
  bit           steady;

  record_page_buffer_directory i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Appends one predicted word for the current command.
  function automatic void note_word(input logic [KIND_W-1:0] kind, input int page, input int pos,
                                    input int off, input bit res);
    result_word_t w;
    w.kind = kind;
    w.page = PAGE_W'(page);
    w.pos  = POS_W'(pos);
    w.off  = OFF_W'(off);
    w.res  = res;
    w.last = 1'b0;
    step_words.push_back(w);
  endfunction

  // Highest slot that holds the page, or -1.
  function automatic int holding_slot(input int page);
    int slot;
    slot = -1;
    for (int i = 0; i < WAYS; i++) begin
      if (dir_valid[i] && dir_page[i] == PAGE_W'(page)) slot = i;
    end
    return slot;
  endfunction

  // Places a page in the highest free slot, evicting the page in slot 0 when full.
  function automatic void install_page(input int page, input bit fetch);
    int slot;
    slot = -1;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (!dir_valid[i] && slot < 0) slot = i;
    end
    if (slot < 0) begin
      note_word(KIND_WRITEBACK, int'(dir_page[0]), 0, 0, 1'b0);
      for (int i = 0; i < WAYS - 1; i++) begin
        dir_page[i]  = dir_page[i + 1];
        dir_valid[i] = dir_valid[i + 1];
      end
      slot = WAYS - 1;
    end
    dir_page[slot]  = PAGE_W'(page);
    dir_valid[slot] = 1'b1;
    if (fetch) note_word(KIND_FETCH, page, slot, 0, 1'b1);
  endfunction

  // Maps a record to its page and offset, brings the page in and reports the access.
  function automatic void map_access(input int rid, input bit is_insert);
    int per_page;
    int page;
    int off;
    int slot;
    per_page = (reg_per_page == '0) ? 1 : int'(reg_per_page);
    page = rid / per_page;
    off  = (rid % per_page) * int'(reg_rsize);
    if (is_insert && longint'(dir_pages) * per_page < longint'(rid) + 1) begin
      // A fresh page is placed without a fetch, even if a copy is already resident.
      install_page(page, 1'b0);
      if (int'(dir_pages) != COUNT_TOP) dir_pages = dir_pages + 1'b1;
    end else if (holding_slot(page) < 0 && page < int'(dir_pages)) begin
      install_page(page, 1'b1);
    end
    slot = holding_slot(page);
    if (slot < 0) note_word(KIND_DONE, page, 0, off, 1'b0);
    else note_word(KIND_DONE, page, slot, off, 1'b1);
  endfunction

  // Runs one command through the directory copy and leaves its words in step_words.
  function automatic void model_command(input logic [CMD_W-1:0] cmd, input logic [RID_W-1:0] rid);
    int id;
    step_words.delete();
    case (cmd)
      CMD_OPEN: begin
        dir_records = reg_start_recs;
        dir_pages   = reg_start_pages;
        for (int i = 0; i < WAYS; i++) begin
          if (int'(dir_pages) > i) begin
            dir_page[i]  = PAGE_W'(i);
            dir_valid[i] = 1'b1;
            note_word(KIND_FETCH, i, i, 0, 1'b1);
          end else begin
            dir_page[i]  = '0;
            dir_valid[i] = 1'b0;
          end
        end
        note_word(KIND_DONE, 0, 0, 0, 1'b0);
      end
      CMD_INSERT: begin
        if (int'(dir_records) >= MAX_RECS) begin
          note_word(KIND_REJECT, 0, 0, 0, 1'b0);
        end else begin
          id = int'(dir_records);
          if (int'(dir_records) != COUNT_TOP) dir_records = dir_records + 1'b1;
          map_access(id, 1'b1);
        end
      end
      CMD_READ, CMD_DELETE, CMD_UPDATE: begin
        if (int'(rid) >= int'(dir_records)) note_word(KIND_REJECT, 0, 0, 0, 1'b0);
        else map_access(int'(rid), 1'b0);
      end
      CMD_COMMIT: begin
        for (int i = 0; i < WAYS; i++) begin
          if (dir_valid[i]) note_word(KIND_WRITEBACK, int'(dir_page[i]), i, 0, 1'b1);
        end
        note_word(KIND_DONE, 0, 0, 0, 1'b0);
      end
      default: note_word(KIND_REJECT, 0, 0, 0, 1'b0);
    endcase
  endfunction

  // Predicts a command, then presents it until the block takes the word.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [RID_W-1:0] rid,
                           input bit checked, input logic [KIND_W-1:0] want);
    result_word_t w;
    model_command(cmd, rid);
    if (checked) begin
      // Answer known by inspection: every field zero but the kind.
      w = '0;
      w.kind = want;
      w.last = 1'b1;
      expected_words.push_back(w);
    end else begin
      foreach (step_words[i]) begin
        w = step_words[i];
        w.last = (i == step_words.size() - 1);
        expected_words.push_back(w);
      end
    end
    cfg_we <= 1'b0;
    while (!steady && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - CMD_W - RID_W){1'b0}}, rid, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Lets every outstanding result word drain, then a short pause.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes one register and mirrors it into the directory copy.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input int value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_W'(value);
    case (idx)
      REG_RECORD_SIZE: reg_rsize       = RSZ_W'(value);
      REG_RECS_PER_PG: reg_per_page    = RSZ_W'(value);
      REG_START_RECS:  reg_start_recs  = CNT_W'(value);
      default:         reg_start_pages = CNT_W'(value);
    endcase
    @(posedge clk);
  endtask

  function automatic plan_row_t cmd_row(input logic [CMD_W-1:0] cmd, input int rid);
    plan_row_t r;
    r = '0;
    r.row = ROW_CMD;
    r.cmd = cmd;
    r.arg = CFG_W'(rid);
    return r;
  endfunction

  function automatic plan_row_t checked_row(input logic [CMD_W-1:0] cmd, input int rid,
                                            input logic [KIND_W-1:0] want);
    plan_row_t r;
    r = cmd_row(cmd, rid);
    r.row  = ROW_CHECKED;
    r.want = want;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [CIDX_W-1:0] idx, input int value);
    plan_row_t r;
    r = '0;
    r.row = ROW_REG;
    r.idx = idx;
    r.arg = CFG_W'(value);
    return r;
  endfunction

  // Picks a low end, a high end or something in between.
  function automatic int pick_value(input int lo, input int hi);
    int r;
    r = int'($urandom_range(3));
    if (r == 0) return lo;
    if (r == 1) return hi;
    return int'($urandom_range(hi, lo));
  endfunction

  // Compares one field of a result word.
  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Result side: random back-pressure, quiet while the steady window is open.
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 10);
  end

  // Every accepted result word is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $error("result word %h (last %0b) with nothing expected", out_tdata, out_tlast);
        mismatches++;
      end else begin
        oldest = expected_words.pop_front();
        compare_field("kind", int'(oldest.kind), int'(out_tdata[KIND_W-1:0]));
        compare_field("page_id", int'(oldest.page), int'(out_tdata[KIND_W +: PAGE_W]));
        compare_field("position", int'(oldest.pos),
                      int'(out_tdata[KIND_W+PAGE_W +: POS_W]));
        compare_field("byte_offset", int'(oldest.off),
                      int'(out_tdata[KIND_W+PAGE_W+POS_W +: OFF_W]));
        compare_field("resident", int'(oldest.res),
                      int'(out_tdata[KIND_W+PAGE_W+POS_W+OFF_W]));
        compare_field("last", int'(oldest.last), int'(out_tlast));
      end
    end
  end

  // Stimulus: reset, the directed plan, then random phases of commands.
  initial begin
    bit               writing;
    int               r;
    int               rc;
    int               per_page;
    int               span;
    int               rid;
    logic [CMD_W-1:0] cmd;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_data  = '0;
    steady    = 1'b0;
    mismatches = 0;
    for (int i = 0; i < WAYS; i++) begin
      dir_page[i]  = '0;
      dir_valid[i] = 1'b0;
    end
    dir_records     = '0;
    dir_pages       = '0;
    reg_rsize       = RSIZE_RST;
    reg_per_page    = RPP_RST;
    reg_start_recs  = '0;
    reg_start_pages = '0;

    // Register defaults after reset: nothing open, empty buffer.
    plan.push_back(checked_row(CMD_READ, 0, KIND_REJECT));
    plan.push_back(checked_row(CMD_BAD_LO, 'h5A5A, KIND_REJECT));
    plan.push_back(checked_row(CMD_BAD_HI, 'hFFFF, KIND_REJECT));
    plan.push_back(checked_row(CMD_COMMIT, 0, KIND_DONE));
    plan.push_back(checked_row(CMD_OPEN, 0, KIND_DONE));
    // Inserts fill the slots from the top, the fourth evicts the page in slot 0.
    plan.push_back(cmd_row(CMD_INSERT, 0));
    plan.push_back(cmd_row(CMD_INSERT, 0));
    plan.push_back(cmd_row(CMD_INSERT, 0));
    plan.push_back(cmd_row(CMD_INSERT, 0));
    plan.push_back(cmd_row(CMD_READ, 0));
    plan.push_back(checked_row(CMD_DELETE, 'hFFFF, KIND_REJECT));
    plan.push_back(cmd_row(CMD_COMMIT, 0));
    // Largest counts: a full open, insert at capacity, the top record id.
    plan.push_back(reg_row(REG_START_RECS, MAX_RECS));
    plan.push_back(reg_row(REG_START_PAGES, MAX_RECS));
    plan.push_back(cmd_row(CMD_OPEN, 0));
    plan.push_back(checked_row(CMD_INSERT, 0, KIND_REJECT));
    plan.push_back(cmd_row(CMD_UPDATE, 'hFFFF));
    plan.push_back(cmd_row(CMD_READ, 'h5555));
    // Two inserts that map to the same fresh page leave it resident twice.
    plan.push_back(reg_row(REG_RECORD_SIZE, 1));
    plan.push_back(reg_row(REG_RECS_PER_PG, 2));
    plan.push_back(reg_row(REG_START_RECS, 20));
    plan.push_back(reg_row(REG_START_PAGES, 0));
    plan.push_back(checked_row(CMD_OPEN, 0, KIND_DONE));
    plan.push_back(cmd_row(CMD_INSERT, 0));
    plan.push_back(cmd_row(CMD_INSERT, 0));
    plan.push_back(cmd_row(CMD_READ, 21));
    plan.push_back(cmd_row(CMD_READ, 0));
    // Zero records per page, then a page past the page count.
    plan.push_back(reg_row(REG_RECORD_SIZE, 80));
    plan.push_back(reg_row(REG_RECS_PER_PG, 0));
    plan.push_back(reg_row(REG_START_RECS, 100));
    plan.push_back(reg_row(REG_START_PAGES, 2));
    plan.push_back(cmd_row(CMD_OPEN, 0));
    plan.push_back(cmd_row(CMD_READ, 99));
    // Offsets beyond seven bits wrap.
    plan.push_back(reg_row(REG_RECS_PER_PG, 80));
    plan.push_back(cmd_row(CMD_READ, 79));
    plan.push_back(cmd_row(CMD_COMMIT, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    writing = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].row == ROW_REG) begin
        if (!writing) wait_drained();
        writing = 1'b1;
        write_reg(plan[i].idx, int'(plan[i].arg));
      end else begin
        writing = 1'b0;
        send_word(plan[i].cmd, plan[i].arg[RID_W-1:0], plan[i].row == ROW_CHECKED,
                  plan[i].want);
      end
    end

    // Random phases: new registers, an open, then a mix biased toward valid accesses.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      steady = (ph == PHASES / 2);
      write_reg(REG_RECORD_SIZE, (ph == 0) ? 80 : (ph == 1) ? 1 : pick_value(1, 80));
      write_reg(REG_RECS_PER_PG, (ph == 0) ? 80 : (ph == 1) ? 1 : pick_value(1, 80));
      r = int'($urandom_range(4));
      write_reg(REG_START_RECS, (ph == 0) ? MAX_RECS : (ph == 1) ? 0 :
                (r == 4) ? int'($urandom_range(400)) : pick_value(0, MAX_RECS));
      r = int'($urandom_range(5));
      write_reg(REG_START_PAGES, (ph == 0) ? MAX_RECS : (ph == 1) ? 0 :
                (r < 3) ? int'($urandom_range(5)) : (r == 3) ? MAX_RECS :
                (r == 4) ? int'($urandom_range(MAX_RECS)) : int'($urandom_range(300)));
      send_word(CMD_OPEN, RID_W'($urandom), 1'b0, KIND_DONE);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        r   = int'($urandom_range(99));
        rc  = int'(dir_records);
        rid = int'($urandom_range(16'hFFFF));
        if (r < 55 && rc > 0) begin
          r   = int'($urandom_range(2));
          cmd = (r == 0) ? CMD_READ : (r == 1) ? CMD_DELETE : CMD_UPDATE;
          per_page = (reg_per_page == '0) ? 1 : int'(reg_per_page);
          span = (rc - 1 < 4 * per_page) ? rc - 1 : 4 * per_page;
          // Mostly low or recently inserted records, so pages get reused.
          r = int'($urandom_range(2));
          if (r == 0) rid = int'($urandom_range(span));
          else if (r == 1) rid = rc - 1 - int'($urandom_range(span));
          else rid = int'($urandom_range(rc - 1));
        end else if (r < 75) begin
          cmd = CMD_INSERT;
        end else if (r < 83) begin
          cmd = CMD_COMMIT;
        end else if (r < 87) begin
          cmd = CMD_OPEN;
        end else if (r < 90) begin
          cmd = $urandom_range(1) ? CMD_BAD_HI : CMD_BAD_LO;
        end else begin
          r   = int'($urandom_range(2));
          cmd = (r == 0) ? CMD_READ : (r == 1) ? CMD_DELETE : CMD_UPDATE;
        end
        send_word(cmd, RID_W'(rid), 1'b0, KIND_DONE);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/rpbd_pkg.sv
rtl/core/rpbd_divider.sv
rtl/core/record_page_buffer_directory.sv
tb/tb_top.sv
